@@ src/assert_macros.svh @@
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define LSVF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define LSVF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/lsvf_pkg.sv @@
package lsvf_pkg;

  localparam int FRAC_BITS = 16;

  localparam int COORD_W = 32;
  localparam int SIZE_W  = 13;
  localparam int W_W     = 29;
  localparam int D_W     = 48;
  localparam int OFF_W   = 64;

  localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(1024);

  // 19*size fits in SIZE_W+5 bits; coordinate sums need one extra bit
  localparam int MUL19_W = SIZE_W + 5;
  localparam int SUM_W   = COORD_W + 1;
  localparam int PROD_W  = MUL19_W + SUM_W;

  // dividend widths of the three quotient kinds
  localparam int NUM_WH = SIZE_W + FRAC_BITS + COORD_W;
  localparam int NUM_D  = MUL19_W + 2 * FRAC_BITS;
  localparam int NUM_O  = MUL19_W + FRAC_BITS + SUM_W;
  localparam int NUM_A  = (NUM_WH > NUM_D) ? NUM_WH : NUM_D;
  localparam int NUM_W  = (NUM_O > NUM_A) ? NUM_O : NUM_A;
  localparam int CNT_W  = $clog2(NUM_W + 1);

  // divisor up to 40 * range
  localparam int DEN_W = COORD_W + 6;

  localparam int QX_W = (NUM_W > OFF_W) ? NUM_W : OFF_W;

  localparam logic [W_W-1:0]   W_MAX   = '1;
  localparam logic [D_W-1:0]   D_MAX   = '1;
  localparam logic [OFF_W-1:0] I64_MAX = {1'b0, {(OFF_W-1){1'b1}}};

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic                      last_line;
  } in_word_t;

  typedef struct packed {
    logic [W_W-1:0]          image_width;
    logic [W_W-1:0]          image_height;
    logic [D_W-1:0]          scale;
    logic signed [OFF_W-1:0] offset_x;
    logic signed [OFF_W-1:0] offset_y;
    logic                    degenerate;
  } out_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_y;
    logic [SIZE_W-1:0]         size;
  } job_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PREP,
    B_LOAD,
    B_DIV,
    B_OUT
  } back_state_t;

  typedef enum logic [2:0] {
    OP_W,
    OP_H,
    OP_D,
    OP_OX,
    OP_OY
  } op_t;

endpackage

@@ src/lsvf_front.sv @@
module lsvf_front import lsvf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  input  logic              q_full,
  output logic              push,
  output job_t              push_job
);

  logic [SIZE_W-1:0]         size_r;
  logic                      started_r;
  logic signed [COORD_W-1:0] min_x_r, max_x_r, min_y_r, max_y_r;

  logic signed [COORD_W-1:0] sx, sy, ex, ey;
  logic signed [COORD_W-1:0] bmin_x, bmax_x, bmin_y, bmax_y;
  logic signed [COORD_W-1:0] tmin_x, tmax_x, tmin_y, tmax_y;
  logic signed [COORD_W-1:0] nmin_x, nmax_x, nmin_y, nmax_y;
  logic                      accept;

  always_comb begin
    sx = in_data.start_x;
    sy = in_data.start_y;
    ex = in_data.end_x;
    ey = in_data.end_y;
    // a fresh set starts its box at the first endpoint
    bmin_x = started_r ? min_x_r : sx;
    bmax_x = started_r ? max_x_r : sx;
    bmin_y = started_r ? min_y_r : sy;
    bmax_y = started_r ? max_y_r : sy;
    tmin_x = (sx < bmin_x) ? sx : bmin_x;
    tmax_x = (sx > bmax_x) ? sx : bmax_x;
    tmin_y = (sy < bmin_y) ? sy : bmin_y;
    tmax_y = (sy > bmax_y) ? sy : bmax_y;
    nmin_x = (ex < tmin_x) ? ex : tmin_x;
    nmax_x = (ex > tmax_x) ? ex : tmax_x;
    nmin_y = (ey < tmin_y) ? ey : tmin_y;
    nmax_y = (ey > tmax_y) ? ey : tmax_y;
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && in_data.last_line;

  always_comb begin
    push_job.min_x = nmin_x;
    push_job.max_x = nmax_x;
    push_job.min_y = nmin_y;
    push_job.max_y = nmax_y;
    push_job.size  = size_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r    <= SIZE_RST;
      started_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
      if (accept) begin
        started_r <= !in_data.last_line;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      min_x_r <= nmin_x;
      max_x_r <= nmax_x;
      min_y_r <= nmin_y;
      max_y_r <= nmax_y;
    end
  end

endmodule

@@ src/lsvf_queue.sv @@
module lsvf_queue import lsvf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  output logic valid,
  output job_t head,
  input  logic pop
);

  job_t               ent_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   cnt_r;

  assign full  = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ src/lsvf_div.sv @@
module lsvf_div import lsvf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  // restoring divider, one quotient bit per cycle; quotient shifts into num_r
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;
  logic             ge;

  always_comb begin
    rem_sh = {rem_r, num_r[NUM_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_r};
    ge     = !diff[DEN_W+1];
  end

  assign rsp.done = done_r;
  assign rsp.quot = num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      num_r <= {num_r[NUM_W-2:0], ge};
    end
  end

endmodule

@@ src/lsvf_back.sv @@
module lsvf_back import lsvf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  job_t      q_head,
  output logic      q_pop,
  output div_req_t  div_req,
  input  div_rsp_t  div_rsp,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  back_state_t state_r, state_nxt;
  op_t         op_r, op_nxt;

  logic [COORD_W-1:0]       xr_r, yr_r, m_r;
  logic signed [SUM_W-1:0]  sumx_r, sumy_r;
  logic [SUM_W-1:0]         absx_r, absy_r;
  logic                     negx_r, negy_r;
  logic [SIZE_W-1:0]        size_r;
  logic [MUL19_W-1:0]       size19_r;
  out_word_t                res_r;
  out_word_t                out_data_r;
  logic                     out_valid_r;

  logic [SUM_W-1:0]   dx, dy;
  logic [MUL19_W-1:0] sz19;
  logic [MUL19_W-1:0] mul_a;
  logic [SUM_W-1:0]   mul_b;
  logic [PROD_W-1:0]  prod;
  logic [NUM_W-1:0]   prod_x;
  logic [DEN_W-1:0]   m_x;
  logic [QX_W-1:0]    q_x;
  logic [W_W-1:0]     q_w;
  logic [D_W-1:0]     q_d;
  logic [OFF_W-1:0]   mag, half, off;
  logic               neg;
  logic               flat;
  out_word_t          res_init;
  logic               div_start;
  logic               out_load;

  always_comb begin
    dx   = {q_head.max_x[COORD_W-1], q_head.max_x} - {q_head.min_x[COORD_W-1], q_head.min_x};
    dy   = {q_head.max_y[COORD_W-1], q_head.max_y} - {q_head.min_y[COORD_W-1], q_head.min_y};
    sz19 = (MUL19_W'(q_head.size) << 4) + (MUL19_W'(q_head.size) << 1)
         + MUL19_W'(q_head.size);
    flat = (xr_r == '0) && (yr_r == '0);
    // result starts cleared, degenerate flag set for a zero box
    res_init            = '0;
    res_init.degenerate = flat;
  end

  // shared multiplier builds the dividend of the current quotient
  always_comb begin
    case (op_r)
      OP_W: begin
        mul_a = MUL19_W'(size_r);
        mul_b = SUM_W'(xr_r);
      end
      OP_H: begin
        mul_a = MUL19_W'(size_r);
        mul_b = SUM_W'(yr_r);
      end
      OP_D: begin
        mul_a = size19_r;
        mul_b = SUM_W'(1);
      end
      OP_OX: begin
        mul_a = size19_r;
        mul_b = absx_r;
      end
      OP_OY: begin
        mul_a = size19_r;
        mul_b = absy_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod   = PROD_W'(mul_a) * PROD_W'(mul_b);
    prod_x = NUM_W'(prod);
    m_x    = DEN_W'(m_r);
    div_req.start = div_start;
    div_req.num = (op_r == OP_D) ? (prod_x << (2 * FRAC_BITS)) : (prod_x << FRAC_BITS);
    case (op_r)
      OP_W, OP_H: div_req.den = m_x;
      OP_D:       div_req.den = (m_x << 4) + (m_x << 2);
      default:    div_req.den = (m_x << 5) + (m_x << 3);
    endcase
  end

  // quotient post-processing: clamps and offset centering
  always_comb begin
    q_x  = QX_W'(div_rsp.quot);
    q_w  = (q_x > QX_W'(W_MAX)) ? W_MAX : q_x[W_W-1:0];
    q_d  = (q_x > QX_W'(D_MAX)) ? D_MAX : q_x[D_W-1:0];
    mag  = (q_x > QX_W'(I64_MAX)) ? I64_MAX : q_x[OFF_W-1:0];
    half = (op_r == OP_OX) ? OFF_W'(res_r.image_width >> 1)
                           : OFF_W'(res_r.image_height >> 1);
    neg  = (op_r == OP_OX) ? negx_r : negy_r;
    if (!neg) begin
      off = half - mag;
    end else if (mag > I64_MAX - half) begin
      off = I64_MAX;
    end else begin
      off = half + mag;
    end
  end

  assign out_load = (state_r == B_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          state_nxt = B_PREP;
        end
      end
      B_PREP: begin
        op_nxt    = OP_W;
        state_nxt = flat ? B_OUT : B_LOAD;
      end
      B_LOAD: begin
        div_start = 1'b1;
        state_nxt = B_DIV;
      end
      B_DIV: begin
        if (div_rsp.done) begin
          if (op_r == OP_OY) begin
            state_nxt = B_OUT;
          end else begin
            op_nxt    = op_t'(op_r + 3'd1);
            state_nxt = B_LOAD;
          end
        end
      end
      B_OUT: begin
        if (out_load) begin
          q_pop     = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      op_r        <= OP_W;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && q_valid) begin
      xr_r     <= dx[COORD_W-1:0];
      yr_r     <= dy[COORD_W-1:0];
      sumx_r   <= {q_head.min_x[COORD_W-1], q_head.min_x}
                + {q_head.max_x[COORD_W-1], q_head.max_x};
      sumy_r   <= {q_head.min_y[COORD_W-1], q_head.min_y}
                + {q_head.max_y[COORD_W-1], q_head.max_y};
      size_r   <= q_head.size;
      size19_r <= sz19;
    end
    if (state_r == B_PREP) begin
      m_r    <= (xr_r > yr_r) ? xr_r : yr_r;
      negx_r <= sumx_r[SUM_W-1];
      negy_r <= sumy_r[SUM_W-1];
      absx_r <= sumx_r[SUM_W-1] ? SUM_W'(-sumx_r) : SUM_W'(sumx_r);
      absy_r <= sumy_r[SUM_W-1] ? SUM_W'(-sumy_r) : SUM_W'(sumy_r);
      res_r  <= res_init;
    end
    if (state_r == B_DIV && div_rsp.done) begin
      case (op_r)
        OP_W:    res_r.image_width  <= q_w;
        OP_H:    res_r.image_height <= q_w;
        OP_D:    res_r.scale        <= q_d;
        OP_OX:   res_r.offset_x     <= off;
        OP_OY:   res_r.offset_y     <= off;
        default: res_r.degenerate   <= 1'b0;
      endcase
    end
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/line_set_viewport_fit.sv @@
// Line-set viewport fit.
// Input words carry one 2D line segment (four signed Q16.16 endpoint
// coordinates) plus a last_line flag. The block keeps the bounding box of
// every endpoint of the current set; the word flagged last_line closes the
// set and, later, one output word fits the set into an image whose longer
// side is image_size pixels: width, height, scale 0.95*size/range, centering
// offsets, and a degenerate flag when the box has no extent.
// Both channels are valid/ready. image_size is written with cfg_we/cfg_wdata
// only while the block is idle, a rule on the user that the block itself does
// not enforce; reset loads 1024. The front takes one line word per cycle
// while its two-entry set queue has room. The back end works on each closed
// set, one set at a time, running five quotients in turn through one
// bit-serial divider; a degenerate set skips the divider.
// Reset clears the box, the queue and the output valid flag. A stalled
// receiver holds the output word; the back end then waits and the front keeps
// taking lines until the queue fills.
module line_set_viewport_fit import lsvf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data
);

  // front -> queue
  logic     push;
  job_t     push_job;
  logic     q_full;
  // queue -> back
  logic     q_valid;
  logic     q_pop;
  job_t     q_head;
  // back <-> divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  // box tracking and config register
  lsvf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  // closed sets waiting for the back end
  lsvf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head),
    .pop      (q_pop)
  );

  // fit sequencer and output register
  lsvf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // shared bit-serial divider
  lsvf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

@@ src/lsvf_checker.sv @@
`include "assert_macros.svh"

module lsvf_checker import lsvf_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  `LSVF_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid, "out_valid high after reset")

  `LSVF_ASSERT(a_hold_valid, out_valid && !out_ready |=> out_valid, "out_valid dropped")

  `LSVF_ASSERT(a_hold_data, out_valid && !out_ready |=> $stable(out_data), "out_data moved")

  `LSVF_ASSERT(a_degen_zero, out_valid && out_data.degenerate |-> out_data.image_width == 0 && out_data.image_height == 0 && out_data.scale == 0 && out_data.offset_x == 0 && out_data.offset_y == 0, "degenerate word not zero")

endmodule

bind line_set_viewport_fit lsvf_checker u_lsvf_checker (.*);
